### sv/fer_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fer_pkg: shared types and constants of the figure-eight reference unit
// Fixed-point widths, path limits, CORDIC schedule and the pipeline word.
// ----------------------------------------------------------------------------
package fer_pkg;

    // field formats
    localparam int FRAC_BITS  = 16;
    localparam int TRIG_STEPS = 16;
    localparam int TIME_W     = 21;
    localparam int OUT_W      = 18;

    // internal CORDIC format: Q30 in a word with headroom for the fold
    localparam int WORK_BITS = 30;
    localparam int CW        = 34;

    // CORDIC iterations per pipeline stage
    localparam int SPS        = 4;
    localparam int NUM_STAGES = (TRIG_STEPS + SPS - 1) / SPS;

    // angle arithmetic width, wide enough for the shifted time and for pi
    localparam int T_SHIFT = WORK_BITS - FRAC_BITS;
    localparam int AW      = (TIME_W + T_SHIFT + 1 > 36) ? TIME_W + T_SHIFT + 1 : 36;

    // constants in Q32 and Q30
    localparam longint TWO_PI_Q32  = 64'sd26986075409;
    localparam longint FOUR_PI_Q32 = 64'sd53972150818;
    localparam longint TWO_PI_W    = 64'sd6746518852;
    localparam longint PI_W        = 64'sd3373259426;
    localparam longint HALF_PI_W   = 64'sd1686629713;
    localparam longint GAIN_W      = 64'sd652032874;

    // path limits rounded to nearest at the time format
    localparam int     LIM_SHIFT = 32 - FRAC_BITS;
    localparam longint TWO_PI_F  = (TWO_PI_Q32 + (64'sd1 <<< (LIM_SHIFT - 1))) >>> LIM_SHIFT;
    localparam longint FOUR_PI_F = (FOUR_PI_Q32 + (64'sd1 <<< (LIM_SHIFT - 1))) >>> LIM_SHIFT;

    // output rounding from Q31 units
    localparam int     OUT_SHIFT = 31 - FRAC_BITS;
    localparam longint OUT_MAX   = 64'sd131071;
    localparam longint OUT_MIN   = -64'sd131072;

    // flags that ride along with each request
    typedef struct packed {
        logic outside;
        logic second;
        logic neg;
    } fer_side_t;

    // one request in flight through the rotator
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        fer_side_t            side;
    } fer_work_t;

    // rotation angle atan(2^-i) in Q30
    function automatic longint atan_at(input int i);
        longint r;
        case (i)
            0:       r = 64'sd843314857;
            1:       r = 64'sd497837829;
            2:       r = 64'sd263043837;
            3:       r = 64'sd133525159;
            4:       r = 64'sd67021687;
            5:       r = 64'sd33543516;
            6:       r = 64'sd16775851;
            7:       r = 64'sd8388437;
            8:       r = 64'sd4194283;
            9:       r = 64'sd2097149;
            10:      r = 64'sd1048576;
            default: r = (i <= WORK_BITS) ? (64'sd1 <<< (WORK_BITS - i)) : 64'sd0;
        endcase
        return r;
    endfunction

endpackage

### sv/fer_fold.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fer_fold: range check and angle reduction
// Flags times outside the path, picks the lobe, folds the angle into
// [-pi/2, pi/2] and registers the CORDIC start vector.
// ----------------------------------------------------------------------------
module fer_fold
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [fer_pkg::TIME_W-1:0]      time_in,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output fer_pkg::fer_work_t                     out_work
);
    import fer_pkg::*;

    localparam logic signed [AW-1:0] TWO_PI_FA  = AW'(TWO_PI_F);
    localparam logic signed [AW-1:0] FOUR_PI_FA = AW'(FOUR_PI_F);
    localparam logic signed [AW-1:0] TWO_PI_A   = AW'(TWO_PI_W);
    localparam logic signed [AW-1:0] PI_A       = AW'(PI_W);
    localparam logic signed [AW-1:0] HALF_PI_A  = AW'(HALF_PI_W);
    localparam logic signed [AW-1:0] NHALF_PI_A = -AW'(HALF_PI_W);

    logic signed [AW-1:0] t_ext;
    logic signed [AW-1:0] ang;
    fer_work_t            work_next;
    fer_work_t            work_reg;
    logic                 valid_reg;
    logic                 advance;

    // stage moves when empty or when downstream takes the request
    assign advance  = !valid_reg || out_ready;
    assign in_ready = advance;

    // range check, lobe select and fold
    always_comb
    begin
        t_ext = {{(AW-TIME_W){time_in[TIME_W-1]}}, time_in};
        work_next.side.outside = (t_ext < 0) || (t_ext >= FOUR_PI_FA);
        work_next.side.second  = (t_ext >= TWO_PI_FA);
        work_next.side.neg     = 1'b0;
        ang = t_ext <<< T_SHIFT;
        if (work_next.side.second)
        begin
            ang = ang - TWO_PI_A;
        end
        if (ang > PI_A)
        begin
            ang = ang - TWO_PI_A;
        end
        if (ang > HALF_PI_A)
        begin
            ang = ang - PI_A;
            work_next.side.neg = 1'b1;
        end
        else if (ang < NHALF_PI_A)
        begin
            ang = ang + PI_A;
            work_next.side.neg = 1'b1;
        end
        work_next.x = CW'(GAIN_W);
        work_next.y = '0;
        work_next.z = ang[CW-1:0];
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    // payload register
    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            work_reg <= work_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_work  = work_reg;

endmodule

### sv/fer_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fer_cordic: pipelined rotation-mode CORDIC
// Each stage register holds one request after SPS micro-rotations;
// the stages hand over with a valid/ready chain so bubbles collapse.
// ----------------------------------------------------------------------------
module fer_cordic
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  fer_pkg::fer_work_t  in_work,
    output logic                out_valid,
    input  logic                out_ready,
    output fer_pkg::fer_work_t  out_work
);
    import fer_pkg::*;

    fer_work_t src       [NUM_STAGES+1];
    logic      src_valid [NUM_STAGES+1];
    logic      rdy       [NUM_STAGES+1];

    assign src[0]             = in_work;
    assign src_valid[0]       = in_valid;
    assign rdy[NUM_STAGES]    = out_ready;
    assign in_ready           = rdy[0];
    assign out_valid          = src_valid[NUM_STAGES];
    assign out_work           = src[NUM_STAGES];

    for (genvar s = 0; s < NUM_STAGES; s++)
    begin : g_stage
        localparam int BASE = s * SPS;

        fer_work_t stage_next;
        fer_work_t stage_reg;
        logic      valid_reg;

        // stage moves when empty or when the next one takes its request
        assign rdy[s] = !valid_reg || rdy[s+1];

        // micro-rotations of this stage
        always_comb
        begin
            logic signed [CW-1:0] dx;
            logic signed [CW-1:0] dy;
            logic signed [CW-1:0] da;
            stage_next = src[s];
            for (int j = 0; j < SPS; j++)
            begin
                if (BASE + j < TRIG_STEPS)
                begin
                    dx = $signed(stage_next.y) >>> (BASE + j);
                    dy = $signed(stage_next.x) >>> (BASE + j);
                    da = CW'(atan_at(BASE + j));
                    if (!stage_next.z[CW-1])
                    begin
                        stage_next.x = stage_next.x - dx;
                        stage_next.y = stage_next.y + dy;
                        stage_next.z = stage_next.z - da;
                    end
                    else
                    begin
                        stage_next.x = stage_next.x + dx;
                        stage_next.y = stage_next.y - dy;
                        stage_next.z = stage_next.z + da;
                    end
                end
            end
        end

        // valid flag
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg <= 1'b0;
            end
            else if (rdy[s])
            begin
                valid_reg <= src_valid[s];
            end
        end

        // payload register
        always_ff @(posedge clk)
        begin
            if (rdy[s] && src_valid[s])
            begin
                stage_reg <= stage_next;
            end
        end

        assign src[s+1]       = stage_reg;
        assign src_valid[s+1] = valid_reg;
    end

endmodule

### sv/fer_round.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fer_round: coordinate forming and output register
// Undoes the fold, forms x and y for the active lobe, rounds half up to
// the output format, saturates and zeroes results outside the path.
// ----------------------------------------------------------------------------
module fer_round
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  fer_pkg::fer_work_t                   in_work,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [fer_pkg::OUT_W-1:0]     ref_x,
    output logic signed [fer_pkg::OUT_W-1:0]     ref_y,
    output logic                                 outside
);
    import fer_pkg::*;

    localparam int RW = CW + 2;
    localparam logic signed [RW-1:0] ONE_W    = RW'(64'sd1 <<< WORK_BITS);
    localparam logic signed [RW-1:0] HALF_LSB = RW'(64'sd1 <<< (OUT_SHIFT - 1));
    localparam logic signed [RW-1:0] MAX_R    = RW'(OUT_MAX);
    localparam logic signed [RW-1:0] MIN_R    = RW'(OUT_MIN);

    logic signed [RW-1:0]    c_val;
    logic signed [RW-1:0]    s_val;
    logic signed [RW-1:0]    xv;
    logic signed [RW-1:0]    yv;
    logic signed [RW-1:0]    xr;
    logic signed [RW-1:0]    yr;
    logic signed [OUT_W-1:0] x_next;
    logic signed [OUT_W-1:0] y_next;
    logic signed [OUT_W-1:0] x_reg;
    logic signed [OUT_W-1:0] y_reg;
    logic                    outside_reg;
    logic                    valid_reg;
    logic                    advance;

    // output register frees when empty or taken
    assign advance  = !valid_reg || out_ready;
    assign in_ready = advance;

    // unfold, form coordinates, round and saturate
    always_comb
    begin
        c_val = {{(RW-CW){in_work.x[CW-1]}}, in_work.x};
        s_val = {{(RW-CW){in_work.y[CW-1]}}, in_work.y};
        if (in_work.side.neg)
        begin
            c_val = -c_val;
            s_val = -s_val;
        end
        xv = ONE_W - c_val;
        yv = s_val;
        if (in_work.side.second)
        begin
            xv = -xv;
            yv = -yv;
        end
        xr = (xv + HALF_LSB) >>> OUT_SHIFT;
        yr = (yv + HALF_LSB) >>> OUT_SHIFT;
        if (xr > MAX_R)
        begin
            xr = MAX_R;
        end
        else if (xr < MIN_R)
        begin
            xr = MIN_R;
        end
        if (yr > MAX_R)
        begin
            yr = MAX_R;
        end
        else if (yr < MIN_R)
        begin
            yr = MIN_R;
        end
        if (in_work.side.outside)
        begin
            x_next = '0;
            y_next = '0;
        end
        else
        begin
            x_next = xr[OUT_W-1:0];
            y_next = yr[OUT_W-1:0];
        end
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            x_reg       <= x_next;
            y_reg       <= y_next;
            outside_reg <= in_work.side.outside;
        end
    end

    assign out_valid = valid_reg;
    assign ref_x     = x_reg;
    assign ref_y     = y_reg;
    assign outside   = outside_reg;

endmodule

### sv/figure_eight_reference_unit.sv
`timescale 1ns / 1ps
// Pipeline: fold register, NUM_STAGES CORDIC stage registers, then the result register.
// Throughput: one request per cycle while ref_stall is low; each pipeline stage frees as its request moves on.
// Depth is set by the CORDIC, four micro-rotations per stage register.
// Reset clears all valid flags at once; payload registers are not reset.
// ----------------------------------------------------------------------------
// figure_eight_reference_unit: figure-eight path reference generator
// Maps a fixed-point time to an x/y point on a two-lobe path using a
// pipelined CORDIC for sine and cosine.
// ----------------------------------------------------------------------------
module figure_eight_reference_unit
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 time_valid,
    output logic                                 time_stall,
    input  logic signed [fer_pkg::TIME_W-1:0]    time_in,
    output logic                                 ref_valid,
    input  logic                                 ref_stall,
    output logic signed [fer_pkg::OUT_W-1:0]     ref_x,
    output logic signed [fer_pkg::OUT_W-1:0]     ref_y,
    output logic                                 outside
);
    import fer_pkg::*;

    fer_work_t fold_work;
    fer_work_t rot_work;
    logic      fold_valid;
    logic      fold_ready;
    logic      rot_valid;
    logic      rot_ready;
    logic      in_ready;

    assign time_stall = !in_ready;

    // range check and angle fold
    fer_fold u_fold
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (time_valid),
        .in_ready  (in_ready),
        .time_in   (time_in),
        .out_valid (fold_valid),
        .out_ready (fold_ready),
        .out_work  (fold_work)
    );

    // sine and cosine
    fer_cordic u_cordic
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fold_valid),
        .in_ready  (fold_ready),
        .in_work   (fold_work),
        .out_valid (rot_valid),
        .out_ready (rot_ready),
        .out_work  (rot_work)
    );

    // coordinates and result register
    fer_round u_round
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rot_valid),
        .in_ready  (rot_ready),
        .in_work   (rot_work),
        .out_valid (ref_valid),
        .out_ready (!ref_stall),
        .ref_x     (ref_x),
        .ref_y     (ref_y),
        .outside   (outside)
    );

endmodule
